// ----- sv/ffba_pkg.sv -----
`default_nettype none
package ffba_pkg;
   localparam int TableEntries = 256;
   localparam int IdxBits = $clog2(TableEntries);
   localparam int CntBits = $clog2(TableEntries + 1);
   localparam int AddrBits = 32;
   localparam int LenBits = 32;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOFIT    = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_ZERO     = 3'd4
   } status_type;

   typedef struct packed {
      logic                is_free;
      logic [AddrBits-1:0] start;
      logic [LenBits-1:0]  length;
   } entry_type;

   // per-cycle command from the controller to every cell
   typedef struct packed {
      logic                write_new;
      logic                split;
      logic                mark_used;
      logic                mark_free;
      logic [IdxBits-1:0]  target;
      logic [CntBits-1:0]  count;
      entry_type           new_entry;
      logic [LenBits-1:0]  req_len;
      logic [AddrBits-1:0] rem_start;
      logic [LenBits-1:0]  rem_len;
   } ctrl_type;
endpackage
`default_nettype wire

// ----- sv/first_fit_block_allocator.sv -----
`default_nettype none
// channel  dir  tdata fields (low bit up)                       tuser
// req      in   command[1:0] length[33:2] address[65:34] (72b)  mark_free
// rsp      out  granted_address[31:0] status[34:32] (40b)       -
// a request is captured at the accepting edge; in the search state the cell row
// is searched with its hits registered, and in the done state all cells update
// and the result is loaded into the output register, where it waits. a new
// request is taken only once the result has left, so requests do not overlap.
// synchronous reset clears the entry count.
module first_fit_block_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // command, length, address
   input  wire logic        req_tuser,  // mark_free
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // granted_address, status
);
   localparam int N = ffba_pkg::TableEntries;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001, S_SEARCH = 3'b010, S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] cmd_ff;
   logic [ffba_pkg::LenBits-1:0] len_ff;
   logic [ffba_pkg::AddrBits-1:0] addr_ff;
   logic mfree_ff;
   logic [ffba_pkg::CntBits-1:0] count_ff, count_in;
   logic fit_ff [N];
   logic ahit_ff [N];
   logic rv_ff, rv_in;
   logic [31:0] rg_ff, rg_in;
   ffba_pkg::status_type rs_ff, rs_in;

   ffba_pkg::ctrl_type ctrl;
   ffba_pkg::entry_type ents [N];
   logic fit [N];
   logic ahit [N];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         ffba_cell u_cell (
            .clock(clock), .idx(g[ffba_pkg::IdxBits-1:0]), .ctrl(ctrl),
            .from_below(ents[(g == 0) ? 0 : g - 1]),
            .probe_len(len_ff), .probe_addr(addr_ff),
            .entry(ents[g]), .fit_hit(fit[g]), .addr_hit(ahit[g]));
      end
   endgenerate

   // priority pick over registered hits
   logic f_found, a_found;
   logic [ffba_pkg::IdxBits-1:0] f_idx, a_idx;
   always_comb begin
      f_found = 1'b0; a_found = 1'b0;
      f_idx = '0; a_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (fit_ff[i]) begin
            f_found = 1'b1; f_idx = i[ffba_pkg::IdxBits-1:0];
         end
         if (ahit_ff[i]) begin
            a_found = 1'b1; a_idx = i[ffba_pkg::IdxBits-1:0];
         end
      end
   end

   ffba_pkg::entry_type hit_e;
   logic full;
   assign hit_e = ents[f_idx];
   assign full = count_ff == ffba_pkg::CntBits'(N);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rv_in = rv_ff && !rsp_tready;
      rg_in = rg_ff;
      rs_in = rs_ff;
      ctrl = '0;
      ctrl.count = count_ff;
      ctrl.req_len = len_ff;
      ctrl.rem_start = hit_e.start + len_ff;
      ctrl.rem_len = hit_e.length - len_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) state_in = S_SEARCH;
         S_SEARCH: state_in = S_DONE;
         S_DONE: begin
            state_in = S_IDLE;
            rv_in = 1'b1;
            rg_in = '0;
            rs_in = ffba_pkg::ST_OK;
            case (ffba_pkg::cmd_type'(cmd_ff))
               ffba_pkg::CMD_ADD: begin
                  if (full) rs_in = ffba_pkg::ST_FULL;
                  else begin
                     ctrl.write_new = 1'b1;
                     ctrl.target = count_ff[ffba_pkg::IdxBits-1:0];
                     ctrl.new_entry = '{is_free: mfree_ff, start: addr_ff, length: len_ff};
                     count_in = count_ff + 1'b1;
                  end
               end
               ffba_pkg::CMD_ALLOC: begin
                  ctrl.target = f_idx;
                  if (len_ff == '0) rs_in = ffba_pkg::ST_ZERO;
                  else if (!f_found) rs_in = ffba_pkg::ST_NOFIT;
                  else if (hit_e.length == len_ff) begin
                     ctrl.mark_used = 1'b1; rg_in = hit_e.start;
                  end else if (full) rs_in = ffba_pkg::ST_FULL;
                  else begin
                     ctrl.split = 1'b1; rg_in = hit_e.start;
                     count_in = count_ff + 1'b1;
                  end
               end
               ffba_pkg::CMD_FREE: begin
                  ctrl.target = a_idx;
                  if (a_found) ctrl.mark_free = 1'b1;
                  else rs_in = ffba_pkg::ST_NOTFOUND;
               end
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {5'd0, rs_ff, rg_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff <= rv_in;
      end
      rg_ff <= rg_in;
      rs_ff <= rs_in;
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tdata[1:0];
         len_ff <= req_tdata[33:2];
         addr_ff <= req_tdata[65:34];
         mfree_ff <= req_tuser;
      end
      for (int i = 0; i < N; i++) begin
         fit_ff[i] <= fit[i];
         ahit_ff[i] <= ahit[i];
      end
   end
endmodule
`default_nettype wire

// ----- sv/ffba_cell.sv -----
`default_nettype none
module ffba_cell (
   input  wire logic                       clock,
   input  wire logic [ffba_pkg::IdxBits-1:0] idx,
   input  wire ffba_pkg::ctrl_type         ctrl,
   input  wire ffba_pkg::entry_type        from_below,
   input  wire logic [ffba_pkg::LenBits-1:0] probe_len,
   input  wire logic [ffba_pkg::AddrBits-1:0] probe_addr,
   output ffba_pkg::entry_type             entry,
   output logic                            fit_hit,
   output logic                            addr_hit
);
   ffba_pkg::entry_type entry_ff, entry_in;
   logic valid;

   assign valid = {1'b0, idx} < ctrl.count;
   assign entry = entry_ff;
   assign fit_hit = valid && entry_ff.is_free && (entry_ff.length >= probe_len);
   assign addr_hit = valid && (entry_ff.start == probe_addr);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.write_new && idx == ctrl.target) begin
         entry_in = ctrl.new_entry;
      end else if (ctrl.mark_used && idx == ctrl.target) begin
         entry_in.is_free = 1'b0;
      end else if (ctrl.mark_free && idx == ctrl.target) begin
         entry_in.is_free = 1'b1;
      end else if (ctrl.split) begin
         if (idx == ctrl.target) begin
            entry_in.is_free = 1'b0;
            entry_in.length = ctrl.req_len;
         end else if ({1'b0, idx} == {1'b0, ctrl.target} + 1'b1) begin
            entry_in.is_free = 1'b1;
            entry_in.start = ctrl.rem_start;
            entry_in.length = ctrl.rem_len;
         end else if (idx > ctrl.target && {1'b0, idx} <= ctrl.count) begin
            entry_in = from_below;  // shift up one
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule
`default_nettype wire
